FILE: rtl/recb_pkg.sv
// ----------------------------------------------------------------------------
// recb_pkg
// shared types, constants and state codes for the ratio/barlow check block
// ----------------------------------------------------------------------------
package recb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FB = 7;          // width of a shift amount up to 64

    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_SQRT = 2'd1
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDIV_GO, S_RDIV_W,
        S_UDIV_GO, S_UDIV_W,
        S_WDIV_GO, S_WDIV_W,
        S_V_MUL,
        S_ESUM,
        S_EQ_GO, S_EQ_W,
        S_DEN,
        S_DQ_GO, S_DQ_W,
        S_SIG_GO, S_SIG_W,
        S_WT_GO, S_WT_W,
        S_TERM,
        S_AVG_GO, S_AVG_W,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [63:0] a;      // dividend or radicand
        logic [63:0] d;      // divisor
        logic [63:0] cap;    // saturation limit
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } unit_rsp_t;

    typedef struct packed {
        logic [31:0] ratio;
        logic [30:0] ratio_error;
        logic        ratio_valid;
        logic        error_clamped;
        logic [30:0] abs_deviation;
        logic [30:0] significance;
        logic        significance_valid;
        logic [30:0] weighted_average;
        logic        average_valid;
        logic        last_out;
    } result_t;

    typedef struct packed {
        logic [31:0] base_value;
        logic [30:0] base_error;
        logic [31:0] syst_value;
        logic [30:0] syst_error;
        logic        last_bin;
    } item_t;

    localparam logic [63:0] MAX31 = 64'h7FFF_FFFF;

endpackage

FILE: rtl/recb_if.sv
// ----------------------------------------------------------------------------
// recb_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface recb_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ratio_error_and_barlow_check.sv
// ----------------------------------------------------------------------------
// one bin at a time: no new bin is taken while the last one is in work;
// the work runs on the shared bit-serial divide/sqrt unit and the
// bit-serial multiplier
// a result waits in an output register; the next bin is taken once it leaves
// reset: asynchronous, active low; clears both sums, sets correlated to 1
// ----------------------------------------------------------------------------
// ratio_error_and_barlow_check
// ratio, ratio error, deviation and barlow significance per histogram bin
// ----------------------------------------------------------------------------
module ratio_error_and_barlow_check (
    input  logic        clk,
    input  logic        rst_n,
    recb_if.sink        in_ch,
    recb_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import recb_pkg::*;

    logic cor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cor_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 1'b0)
            cor_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'd0, cor_reg} : 32'd0;

    recb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .correlated(cor_reg),
        .in_valid  (in_ch.valid),
        .in_data   (in_ch.data),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data),
        .out_ready (out_ch.ready)
    );
endmodule

FILE: rtl/recb_mul.sv
// ----------------------------------------------------------------------------
// recb_mul
// 64x64 shift-and-add multiplier, one multiplier bit per cycle, 128-bit product
// ----------------------------------------------------------------------------
module recb_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] product
);
    import recb_pkg::*;

    logic [127:0] acc_reg, acc_next;
    logic [127:0] mcand_reg, mcand_next;
    logic [63:0]  mplier_reg, mplier_next;
    logic [FB-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = {64'd0, a};
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[126:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[63:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == FB'(63))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: rtl/recb_unit.sv
// ----------------------------------------------------------------------------
// recb_unit
// shared bit-serial divider (fixed-point, saturating) and square root
// ----------------------------------------------------------------------------
module recb_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  recb_pkg::unit_req_t  req,
    output recb_pkg::unit_rsp_t  rsp
);
    import recb_pkg::*;

    // divide: 64 integer quotient bits then FRAC_BITS fraction bits,
    // 65-bit remainder keeps the shifted-out top bit
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  num_reg, num_next;
    logic [63:0]  den_reg, den_next;
    logic [63+FRAC_BITS:0] q_reg, q_next;
    logic [63:0]  cap_reg, cap_next;
    logic [FB:0]  cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    op_t          op_reg, op_next;
    // square root
    logic [63:0]  x_reg, x_next;
    logic [63:0]  r_reg, r_next;
    logic [63:0]  bit_reg, bit_next;

    logic [64:0]  rem_sh;
    logic         ge;
    logic [63:0]  rb;
    logic [63:0]  res;
    logic [63+FRAC_BITS:0] capx;

    always_comb
    begin
        rem_sh = {rem_reg[63:0], num_reg[63]};
        ge     = rem_sh >= {1'b0, den_reg};
        rb     = r_reg + bit_reg;
        capx   = {{FRAC_BITS{1'b0}}, cap_reg};
        res    = (q_reg > capx) ? cap_reg : q_reg[63:0];
    end

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        den_next = den_reg;
        q_next   = q_reg;
        cap_next = cap_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next  = op_reg;
        x_next   = x_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.a;
            den_next  = req.d;
            cap_next  = req.cap;
            q_next    = '0;
            x_next    = req.a;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                num_next = {num_reg[62:0], 1'b0};
                q_next   = {q_reg[62+FRAC_BITS:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (FB+1)'(64 + FRAC_BITS - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                if (bit_reg != '0)
                begin
                    if (x_reg >= rb)
                    begin
                        x_next = x_reg - rb;
                        r_next = {1'b0, r_reg[63:1]} + bit_reg;
                    end
                    else
                        r_next = {1'b0, r_reg[63:1]};
                    bit_next = {2'b00, bit_reg[63:2]};
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cap_reg <= cap_next;
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_DIV) ? res : r_reg;
endmodule

FILE: rtl/recb_ctrl.sv
// ----------------------------------------------------------------------------
// recb_ctrl
// per-bin sequencer: issues divides, roots and multiplies, keeps the sums
// ----------------------------------------------------------------------------
module recb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 correlated,
    input  logic                 in_valid,
    input  recb_pkg::item_t      in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output recb_pkg::result_t    out_data,
    input  logic                 out_ready
);
    import recb_pkg::*;

    state_t state_reg, state_next;
    item_t  it_reg, it_next;
    result_t res_reg, res_next;
    logic    rv_reg, rv_next;
    logic [63:0] bmag_reg, bmag_next, smag_reg, smag_next;
    logic        neg_reg, neg_next, cor_reg, cor_next;
    logic [63:0] rmag_reg, rmag_next, u_reg, u_next, v_reg, v_next;
    logic [63:0] t_reg, t_next;     // scratch: den2, sqrt(den2), wt
    logic [63:0] sig_reg, sig_next;
    logic [63:0] wsum_reg, wsum_next, dsum_reg, dsum_next;
    logic [1:0]  mph_reg, mph_next; // multiply phase within a state
    logic [127:0] acc_reg, acc_next;

    unit_req_t req;
    unit_rsp_t rsp;
    logic         mstart;
    logic [63:0]  ma, mb;
    logic         mdone;
    logic [127:0] mprod;

    recb_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    recb_mul  u_mul  (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                      .done(mdone), .product(mprod));

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [63:0] bext, sext;
    logic [64:0] dsub;
    logic [63:0] ratio64, dev64, num64;
    logic [64:0] dr;
    logic [64:0] wadd, dadd;
    logic [63:0] eb64, es64;

    always_comb
    begin
        bext  = {{32{it_reg.base_value[31]}}, it_reg.base_value};
        sext  = {{32{it_reg.syst_value[31]}}, it_reg.syst_value};
        eb64  = {33'd0, it_reg.base_error};
        es64  = {33'd0, it_reg.syst_error};
        dsub  = {bext[63], bext} - {sext[63], sext};
        num64 = dsub[64] ? 64'(-dsub) : dsub[63:0];
        ratio64 = (rv_reg && neg_reg) ? -rmag_reg : (rv_reg ? rmag_reg : '0);
        dr    = {ratio64[63], ratio64} - {1'b0, ONE};
        dev64 = dr[64] ? 64'(-dr) : dr[63:0];
        if (dev64 > MAX31)
            dev64 = MAX31;
        wadd = {1'b0, wsum_reg} + {1'b0, t_reg};
        dadd = {1'b0, dsum_reg} + {1'b0, acc_reg[63:0]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid && in_ready)
                           state_next = S_RDIV_GO;
            S_RDIV_GO: state_next = (bmag_reg == '0) ? S_EQ_GO : S_RDIV_W;
            S_RDIV_W:  if (rsp.done) state_next = S_UDIV_GO;
            S_UDIV_GO: state_next = S_UDIV_W;
            S_UDIV_W:  if (rsp.done) state_next = S_WDIV_GO;
            S_WDIV_GO: state_next = S_WDIV_W;
            S_WDIV_W:  if (rsp.done) state_next = S_V_MUL;
            S_V_MUL:   if (mdone) state_next = S_ESUM;
            S_ESUM:    if (mdone && mph_reg == 2'd2) state_next = S_EQ_GO;
            S_EQ_GO:   state_next = rv_reg ? S_EQ_W : S_DEN;
            S_EQ_W:    if (rsp.done) state_next = S_DEN;
            S_DEN:     if (mdone && mph_reg == 2'd1) state_next = S_DQ_GO;
            S_DQ_GO:   state_next = (t_reg == '0) ? S_WT_GO : S_DQ_W;
            S_DQ_W:    if (rsp.done) state_next = S_SIG_GO;
            S_SIG_GO:  state_next = S_SIG_W;
            S_SIG_W:   if (rsp.done) state_next = S_WT_GO;
            S_WT_GO:   state_next = (sig_reg == '0) ? S_AVG_GO : S_WT_W;
            S_WT_W:    if (rsp.done) state_next = S_TERM;
            S_TERM:    if (mdone) state_next = S_AVG_GO;
            S_AVG_GO:  state_next = (it_reg.last_bin && wsum_reg != '0) ? S_AVG_W : S_OUT;
            S_AVG_W:   if (rsp.done) state_next = S_OUT;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        it_next   = it_reg;
        res_next  = res_reg;
        rv_next   = rv_reg;
        bmag_next = bmag_reg;
        smag_next = smag_reg;
        neg_next  = neg_reg;
        cor_next  = cor_reg;
        rmag_next = rmag_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        t_next    = t_reg;
        sig_next  = sig_reg;
        wsum_next = wsum_reg;
        dsum_next = dsum_reg;
        mph_next  = mph_reg;
        acc_next  = acc_reg;
        req       = '0;
        mstart    = 1'b0;
        ma        = '0;
        mb        = '0;
        case (state_reg)
            S_IDLE:
            begin
                it_next   = in_data;
                bmag_next = in_data.base_value[31] ? 64'(-{{32{1'b1}}, in_data.base_value})
                                                   : {32'd0, in_data.base_value};
                smag_next = in_data.syst_value[31] ? 64'(-{{32{1'b1}}, in_data.syst_value})
                                                   : {32'd0, in_data.syst_value};
                neg_next  = in_data.base_value[31] ^ in_data.syst_value[31];
                cor_next  = correlated;
                rv_next   = 1'b0;
                rmag_next = '0;
                acc_next  = '0;
                sig_next  = '0;
                res_next  = '0;
            end
            S_RDIV_GO:
            begin
                rv_next = (bmag_reg != '0);
                req.start = (bmag_reg != '0);
                req.op  = OP_DIV;
                req.a   = smag_reg;
                req.d   = bmag_reg;
                req.cap = MAX31 + 64'd1;
            end
            S_RDIV_W:
                if (rsp.done)
                    rmag_next = (!neg_reg && rsp.result > MAX31) ? MAX31 : rsp.result;
            S_UDIV_GO:
            begin
                req.start = 1'b1;
                req.op  = OP_DIV;
                req.a   = es64;
                req.d   = bmag_reg;
                req.cap = MAX31;
            end
            S_UDIV_W:
                if (rsp.done)
                    u_next = rsp.result;
            S_WDIV_GO:
            begin
                req.start = 1'b1;
                req.op  = OP_DIV;
                req.a   = eb64;
                req.d   = bmag_reg;
                req.cap = MAX31;
            end
            S_WDIV_W:
                if (rsp.done)
                begin
                    mstart = 1'b1;
                    ma = rmag_reg;
                    mb = rsp.result;
                end
            S_V_MUL:
                if (mdone)
                begin
                    v_next = (mprod[127:FRAC_BITS] > (128-FRAC_BITS)'(MAX31)) ? MAX31
                                                                 : mprod[FRAC_BITS+63:FRAC_BITS];
                    mstart = 1'b1;
                    ma = u_reg;
                    mb = u_reg;
                    mph_next = 2'd0;
                end
            S_ESUM:
                if (mdone)
                begin
                    mph_next = mph_reg + 2'd1;
                    case (mph_reg)
                        2'd0:
                        begin
                            acc_next = mprod;           // u*u
                            mstart = 1'b1; ma = v_reg; mb = v_reg;
                        end
                        2'd1:
                        begin
                            acc_next = acc_reg + mprod; // + v*v
                            mstart = 1'b1; ma = u_reg << 1; mb = v_reg;
                        end
                        default:
                        begin
                            if (cor_reg && rmag_reg != '0)
                            begin
                                if (!neg_reg)
                                begin
                                    if (mprod > acc_reg)
                                    begin
                                        acc_next = '0;
                                        res_next.error_clamped = 1'b1;
                                    end
                                    else
                                        acc_next = acc_reg - mprod;
                                end
                                else
                                    acc_next = acc_reg + mprod;
                            end
                        end
                    endcase
                end
            S_EQ_GO:
            begin
                req.start = rv_reg;
                req.op = OP_SQRT;
                req.a  = acc_reg[63:0];
                // first square of the barlow denominator
                mstart = 1'b1; ma = eb64; mb = eb64;
                mph_next = 2'd0;
            end
            S_EQ_W:
                if (rsp.done)
                    res_next.ratio_error = (rsp.result > MAX31) ? 31'(MAX31)
                                                                : rsp.result[30:0];
            S_DEN:
                if (mdone)
                begin
                    mph_next = mph_reg + 2'd1;
                    if (mph_reg == 2'd0)
                    begin
                        t_next = mprod[63:0];
                        mstart = 1'b1; ma = es64; mb = es64;
                    end
                    else if (cor_reg)
                        t_next = (t_reg >= mprod[63:0]) ? t_reg - mprod[63:0]
                                                        : mprod[63:0] - t_reg;
                    else
                        t_next = t_reg + mprod[63:0];
                end
            S_DQ_GO:
            begin
                req.start = (t_reg != '0);
                req.op = OP_SQRT;
                req.a  = t_reg;
            end
            S_DQ_W:
                if (rsp.done)
                    t_next = rsp.result;
            S_SIG_GO:
            begin
                res_next.significance_valid = 1'b1;
                req.start = 1'b1;
                req.op  = OP_DIV;
                req.a   = num64;
                req.d   = t_reg;
                req.cap = MAX31;
            end
            S_SIG_W:
                if (rsp.done)
                    sig_next = rsp.result;
            S_WT_GO:
            begin
                req.start = (sig_reg != '0);
                req.op  = OP_DIV;
                req.a   = ONE;
                req.d   = sig_reg;
                req.cap = '1;
            end
            S_WT_W:
                if (rsp.done)
                begin
                    t_next = rsp.result;
                    mstart = 1'b1; ma = rsp.result; mb = dev64;
                end
            S_TERM:
                if (mdone)
                begin
                    // product over 64 bits means wt*dev overflowed
                    acc_next = (mprod[127:64] != '0) ? {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}
                                                     : {64'd0, 64'(mprod[63:0] >> FRAC_BITS)};
                    wsum_next = wadd[64] ? '1 : wadd[63:0];
                end
            S_AVG_GO:
            begin
                if (state_reg == S_AVG_GO && sig_reg != '0)
                    dsum_next = dadd[64] ? '1 : dadd[63:0];
                req.start = it_reg.last_bin && wsum_reg != '0;
                req.op  = OP_DIV;
                req.a   = (sig_reg != '0) ? (dadd[64] ? '1 : dadd[63:0]) : dsum_reg;
                req.d   = wsum_reg;
                req.cap = MAX31;
            end
            S_AVG_W:
                if (rsp.done)
                begin
                    res_next.weighted_average = rsp.result[30:0];
                    res_next.average_valid = 1'b1;
                end
            S_OUT:
            begin
                res_next.ratio = ratio64[31:0];
                res_next.ratio_valid = rv_reg;
                res_next.abs_deviation = dev64[30:0];
                res_next.significance = sig_reg[30:0];
                res_next.last_out = it_reg.last_bin;
                if (it_reg.last_bin)
                begin
                    wsum_next = '0;
                    dsum_next = '0;
                end
            end
            default: ;
        endcase
    end

    function automatic logic rv_out_full();
        rv_out_full = out_valid && !out_ready;
    endfunction

    // output holding register
    always_comb
    begin
        in_ready = (state_reg == S_IDLE) && !rv_out_full();
    end

    logic ov_reg, ov_next;
    result_t od_reg, od_next;

    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (state_reg == S_OUT)
        begin
            ov_next = 1'b1;
            od_next = res_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            wsum_reg  <= '0;
            dsum_reg  <= '0;
            mph_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            wsum_reg  <= wsum_next;
            dsum_reg  <= dsum_next;
            mph_reg   <= mph_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        res_reg  <= res_next;
        bmag_reg <= bmag_next;
        smag_reg <= smag_next;
        neg_reg  <= neg_next;
        cor_reg  <= cor_next;
        rmag_reg <= rmag_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        t_reg    <= t_next;
        sig_reg  <= sig_next;
        acc_reg  <= acc_next;
        od_reg   <= od_next;
    end
endmodule
